FILE: rtl/core/humidity_temperature_calibrator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the humidity/temperature calibrator core
// Shorthand for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMPERATURE_CALIBRATOR_CORE_ASSERT_SVH
`define HUMIDITY_TEMPERATURE_CALIBRATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define HTC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define HTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/htc_pkg.sv
// ----------------------------------------------------------------------------
// htc_pkg
// Widths, register codes and pipeline types of the calibrator core.
// ----------------------------------------------------------------------------
package htc_pkg;

   localparam int RAW_W      = 16;              // raw readings
   localparam int DIFF_W     = RAW_W + 1;       // difference of two raw readings
   localparam int HUM_PT_W   = 8;               // humidity point, half percent
   localparam int PT_W       = 10;              // point width common to both lanes
   localparam int SPAN_W     = PT_W + 4;        // 8 * (p1 - p0), signed
   localparam int BASE_W     = PT_W + 3;        // 8 * p0
   localparam int PROD_W     = DIFF_W + SPAN_W; // span * (x - x0), signed
   localparam int NUM_W      = 30;              // |numerator| bound
   localparam int DEN_W      = 16;              // |denominator| bound
   localparam int DIV_STAGES = NUM_W;           // one quotient bit per stage
   localparam int HUM_OUT_W  = 11;
   localparam int SUM_W      = 32;
   localparam int CSR_IDX_W  = 3;

   localparam logic [HUM_OUT_W-1:0] HUM_MAX_X16 = 11'd1600;
   localparam logic [RAW_W-1:0]     TEMP_MAX    = 16'h7FFF;
   localparam logic [RAW_W-1:0]     TEMP_MIN    = 16'h8000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HUM_POINT0  = 3'd0,
      CSR_HUM_POINT1  = 3'd1,
      CSR_HUM_RAW0    = 3'd2,
      CSR_HUM_RAW1    = 3'd3,
      CSR_TEMP_POINT0 = 3'd4,
      CSR_TEMP_POINT1 = 3'd5,
      CSR_TEMP_RAW0   = 3'd6,
      CSR_TEMP_RAW1   = 3'd7
   } csr_index_type;

   // One lane's item inside the divider: partial remainder, numerator bits
   // shifting out while quotient bits shift in, and the sideband.
   typedef struct packed {
      logic [DEN_W-1:0]  rem;
      logic [NUM_W-1:0]  nq;
      logic [DEN_W-1:0]  den;
      logic              neg;
      logic              bad;
      logic [BASE_W-1:0] base;
   } div_data_type;

endpackage

FILE: rtl/core/humidity_temperature_calibrator_core.sv
// ----------------------------------------------------------------------------
// humidity_temperature_calibrator_core
// Two-point linear calibration of raw humidity and temperature readings.
// ----------------------------------------------------------------------------
// Usage:
//  - csr_*: register writes (index 0..7, data in the low bits of csr_wdata).
//    Always ready; write only while no reading is in flight.
//  - req_*: one raw humidity/temperature pair per transfer.
//  - rsp_*: one calibrated result per request, in order, with the
//    calibration-fault and saturation flags.
//  - A request transfer reaches rsp_valid through three front stages
//    (the first loads on the accepting edge unless the pipeline is held),
//    a 30-stage divider (one quotient bit a stage) and the output register.
//  - Throughput is one pair per cycle when not held; both lanes in lockstep.
//  - While a result waits with rsp_ready low the whole pipeline holds. One
//    further request is still taken into an input skid register, after which
//    req_ready drops until the pipeline moves again.
//  - Reset clears the calibration registers to zero and empties the
//    pipeline; datapath registers keep whatever they held.
// ----------------------------------------------------------------------------
`include "humidity_temperature_calibrator_core_assert.svh"

module humidity_temperature_calibrator_core (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [htc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [htc_pkg::RAW_W-1:0]           csr_wdata,
   // requests
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [htc_pkg::RAW_W-1:0]    req_hum_raw,
   input  logic signed [htc_pkg::RAW_W-1:0]    req_temp_raw,
   // results
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [htc_pkg::HUM_OUT_W-1:0]       rsp_humidity_x16,
   output logic signed [htc_pkg::RAW_W-1:0]    rsp_temperature_x64,
   output logic                                rsp_hum_cal_bad,
   output logic                                rsp_temp_cal_bad,
   output logic                                rsp_temp_saturated
);

   logic [htc_pkg::HUM_PT_W-1:0]    hum_point0_ff, hum_point1_ff;
   logic signed [htc_pkg::RAW_W-1:0] hum_raw0_ff, hum_raw1_ff;
   logic [htc_pkg::PT_W-1:0]        temp_point0_ff, temp_point1_ff;
   logic signed [htc_pkg::RAW_W-1:0] temp_raw0_ff, temp_raw1_ff;

   logic                             skid_valid_ff;
   logic signed [htc_pkg::RAW_W-1:0] skid_hum_ff, skid_temp_ff;
   logic                             advance;
   logic                             req_accept;
   logic                             front_valid;
   logic signed [htc_pkg::RAW_W-1:0] front_hum, front_temp;

   logic                             hum_prep_valid, temp_prep_valid;
   htc_pkg::div_data_type            hum_prep_data, temp_prep_data;
   logic                             hum_div_valid, temp_div_valid;
   htc_pkg::div_data_type            hum_div_data, temp_div_data;

   // ---------------- configuration registers ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hum_point0_ff  <= '0;
         hum_point1_ff  <= '0;
         hum_raw0_ff    <= '0;
         hum_raw1_ff    <= '0;
         temp_point0_ff <= '0;
         temp_point1_ff <= '0;
         temp_raw0_ff   <= '0;
         temp_raw1_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            htc_pkg::CSR_HUM_POINT0:  hum_point0_ff  <= csr_wdata[htc_pkg::HUM_PT_W-1:0];
            htc_pkg::CSR_HUM_POINT1:  hum_point1_ff  <= csr_wdata[htc_pkg::HUM_PT_W-1:0];
            htc_pkg::CSR_HUM_RAW0:    hum_raw0_ff    <= csr_wdata;
            htc_pkg::CSR_HUM_RAW1:    hum_raw1_ff    <= csr_wdata;
            htc_pkg::CSR_TEMP_POINT0: temp_point0_ff <= csr_wdata[htc_pkg::PT_W-1:0];
            htc_pkg::CSR_TEMP_POINT1: temp_point1_ff <= csr_wdata[htc_pkg::PT_W-1:0];
            htc_pkg::CSR_TEMP_RAW0:   temp_raw0_ff   <= csr_wdata;
            htc_pkg::CSR_TEMP_RAW1:   temp_raw1_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- input skid and pipeline enable ----------------
   assign advance    = !rsp_valid || rsp_ready;
   assign req_ready  = !skid_valid_ff;
   assign req_accept = req_valid && req_ready;

   // skid holds a transfer taken while the pipeline was held
   assign front_valid = skid_valid_ff || req_accept;
   assign front_hum   = skid_valid_ff ? skid_hum_ff  : req_hum_raw;
   assign front_temp  = skid_valid_ff ? skid_temp_ff : req_temp_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (advance) begin
         skid_valid_ff <= 1'b0;
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && !advance) begin
         skid_hum_ff  <= req_hum_raw;
         skid_temp_ff <= req_temp_raw;
      end
   end

   // ---------------- lanes ----------------
   htc_prep u_hum_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .x         (front_hum),
      .x0        (hum_raw0_ff),
      .x1        (hum_raw1_ff),
      .p0        ({{(htc_pkg::PT_W-htc_pkg::HUM_PT_W){1'b0}}, hum_point0_ff}),
      .p1        ({{(htc_pkg::PT_W-htc_pkg::HUM_PT_W){1'b0}}, hum_point1_ff}),
      .out_valid (hum_prep_valid),
      .out_data  (hum_prep_data)
   );

   htc_prep u_temp_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .x         (front_temp),
      .x0        (temp_raw0_ff),
      .x1        (temp_raw1_ff),
      .p0        (temp_point0_ff),
      .p1        (temp_point1_ff),
      .out_valid (temp_prep_valid),
      .out_data  (temp_prep_data)
   );

   htc_div u_hum_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (hum_prep_valid),
      .in_data   (hum_prep_data),
      .out_valid (hum_div_valid),
      .out_data  (hum_div_data)
   );

   htc_div u_temp_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (temp_prep_valid),
      .in_data   (temp_prep_data),
      .out_valid (temp_div_valid),
      .out_data  (temp_div_data)
   );

   htc_post u_post (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .in_valid        (hum_div_valid),
      .hum_data        (hum_div_data),
      .temp_data       (temp_div_data),
      .out_valid       (rsp_valid),
      .humidity_x16    (rsp_humidity_x16),
      .temperature_x64 (rsp_temperature_x64),
      .hum_cal_bad     (rsp_hum_cal_bad),
      .temp_cal_bad    (rsp_temp_cal_bad),
      .temp_saturated  (rsp_temp_saturated)
   );

   // ---------------- checks ----------------
   `HTC_ASSERT_IMPLY(a_lanes_lockstep, clock, reset, 1'b1,
      hum_div_valid == temp_div_valid, "lane valid bits diverged")
   `HTC_ASSERT_NEXT(a_stall_into_skid, clock, reset, req_accept && !advance,
      skid_valid_ff, "request transfer lost during stall")
   `HTC_ASSERT_IMPLY(a_hum_bad_zero, clock, reset, rsp_valid && rsp_hum_cal_bad,
      rsp_humidity_x16 == '0, "humidity not zero on bad calibration")
   `HTC_ASSERT_IMPLY(a_temp_bad_zero, clock, reset, rsp_valid && rsp_temp_cal_bad,
      (rsp_temperature_x64 == '0) && !rsp_temp_saturated,
      "temperature not zero on bad calibration")
   `HTC_ASSERT_IMPLY(a_hum_range, clock, reset, rsp_valid,
      rsp_humidity_x16 <= htc_pkg::HUM_MAX_X16, "humidity above full scale")

endmodule

FILE: rtl/core/htc_prep.sv
// ----------------------------------------------------------------------------
// htc_prep
// Three front stages of one lane: differences, product, magnitudes.
// ----------------------------------------------------------------------------
module htc_prep (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             in_valid,
   input  logic signed [htc_pkg::RAW_W-1:0] x,
   input  logic signed [htc_pkg::RAW_W-1:0] x0,
   input  logic signed [htc_pkg::RAW_W-1:0] x1,
   input  logic        [htc_pkg::PT_W-1:0]  p0,
   input  logic        [htc_pkg::PT_W-1:0]  p1,
   output logic                             out_valid,
   output htc_pkg::div_data_type            out_data
);

   // stage 1
   logic                               v1_ff;
   logic signed [htc_pkg::DIFF_W-1:0]  diff_ff,  diff_in;
   logic signed [htc_pkg::DIFF_W-1:0]  den_ff,   den_in;
   logic signed [htc_pkg::SPAN_W-1:0]  span_ff,  span_in;
   logic        [htc_pkg::BASE_W-1:0]  base1_ff, base1_in;
   logic                               bad1_ff,  bad1_in;
   logic signed [htc_pkg::PT_W:0]      pdiff;

   // stage 2
   logic                               v2_ff;
   logic signed [htc_pkg::PROD_W-1:0]  prod_ff,    prod_in;
   logic        [htc_pkg::DEN_W-1:0]   den_mag_ff, den_mag_in;
   logic                               den_neg_ff, den_neg_in;
   logic        [htc_pkg::BASE_W-1:0]  base2_ff;
   logic                               bad2_ff;
   logic        [htc_pkg::DIFF_W-1:0]  den_abs;

   // stage 3
   logic                               v3_ff;
   htc_pkg::div_data_type              entry_ff, entry_in;
   logic        [htc_pkg::PROD_W-1:0]  prod_mag;

   always_comb begin
      diff_in  = {x[htc_pkg::RAW_W-1], x} - {x0[htc_pkg::RAW_W-1], x0};
      den_in   = {x1[htc_pkg::RAW_W-1], x1} - {x0[htc_pkg::RAW_W-1], x0};
      pdiff    = {1'b0, p1} - {1'b0, p0};
      span_in  = {pdiff, 3'b000};
      base1_in = {p0, 3'b000};
      bad1_in  = (x1 == x0);
   end

   always_comb begin
      prod_in    = diff_ff * span_ff;
      den_neg_in = den_ff[htc_pkg::DIFF_W-1];
      den_abs    = den_neg_in ? -den_ff : den_ff;
      den_mag_in = den_abs[htc_pkg::DEN_W-1:0];
   end

   always_comb begin
      prod_mag      = prod_ff[htc_pkg::PROD_W-1] ? -prod_ff : prod_ff;
      entry_in.rem  = '0;
      entry_in.nq   = prod_mag[htc_pkg::NUM_W-1:0];
      entry_in.den  = den_mag_ff;
      // sign of a truncating quotient
      entry_in.neg  = prod_ff[htc_pkg::PROD_W-1] ^ den_neg_ff;
      entry_in.bad  = bad2_ff;
      entry_in.base = base2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         diff_ff    <= diff_in;
         den_ff     <= den_in;
         span_ff    <= span_in;
         base1_ff   <= base1_in;
         bad1_ff    <= bad1_in;
         prod_ff    <= prod_in;
         den_mag_ff <= den_mag_in;
         den_neg_ff <= den_neg_in;
         base2_ff   <= base1_ff;
         bad2_ff    <= bad1_ff;
         entry_ff   <= entry_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = entry_ff;

endmodule

FILE: rtl/core/htc_div.sv
// ----------------------------------------------------------------------------
// htc_div
// Pipelined restoring divider, unsigned magnitudes, one quotient bit a stage.
// ----------------------------------------------------------------------------
module htc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  htc_pkg::div_data_type in_data,
   output logic                  out_valid,
   output htc_pkg::div_data_type out_data
);

   logic                  valid_ff [htc_pkg::DIV_STAGES];
   htc_pkg::div_data_type data_ff  [htc_pkg::DIV_STAGES];

   for (genvar s = 0; s < htc_pkg::DIV_STAGES; s++) begin : g_stage
      htc_pkg::div_data_type       src;
      htc_pkg::div_data_type       data_in;
      logic                        src_valid;
      logic [htc_pkg::DEN_W:0]     trial;
      logic [htc_pkg::DEN_W:0]     trial_sub;
      logic                        ge;

      if (s == 0) begin : g_first
         assign src       = in_data;
         assign src_valid = in_valid;
      end else begin : g_rest
         assign src       = data_ff[s-1];
         assign src_valid = valid_ff[s-1];
      end

      always_comb begin
         trial        = {src.rem, src.nq[htc_pkg::NUM_W-1]};
         trial_sub    = trial - {1'b0, src.den};
         ge           = (trial >= {1'b0, src.den});
         data_in      = src;
         data_in.rem  = ge ? trial_sub[htc_pkg::DEN_W-1:0] : trial[htc_pkg::DEN_W-1:0];
         data_in.nq   = {src.nq[htc_pkg::NUM_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            data_ff[s] <= data_in;
         end
      end
   end

   assign out_valid = valid_ff[htc_pkg::DIV_STAGES-1];
   assign out_data  = data_ff[htc_pkg::DIV_STAGES-1];

endmodule

FILE: rtl/core/htc_post.sv
// ----------------------------------------------------------------------------
// htc_post
// Signs the quotients, adds the base points, clamps and holds the result.
// ----------------------------------------------------------------------------
module htc_post (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             in_valid,
   input  htc_pkg::div_data_type            hum_data,
   input  htc_pkg::div_data_type            temp_data,
   output logic                             out_valid,
   output logic [htc_pkg::HUM_OUT_W-1:0]    humidity_x16,
   output logic signed [htc_pkg::RAW_W-1:0] temperature_x64,
   output logic                             hum_cal_bad,
   output logic                             temp_cal_bad,
   output logic                             temp_saturated
);

   logic                             valid_ff;
   logic [htc_pkg::HUM_OUT_W-1:0]    hum_ff,      hum_in;
   logic [htc_pkg::RAW_W-1:0]        temp_ff,     temp_in;
   logic                             hum_bad_ff;
   logic                             temp_bad_ff;
   logic                             temp_sat_ff, temp_sat_in;

   logic signed [htc_pkg::NUM_W:0]   hum_q, temp_q;
   logic signed [htc_pkg::SUM_W-1:0] hum_sum, temp_sum;
   logic        [htc_pkg::SUM_W-1:0] temp_sum_u;

   always_comb begin
      hum_q  = hum_data.neg  ? -$signed({1'b0, hum_data.nq})  : $signed({1'b0, hum_data.nq});
      temp_q = temp_data.neg ? -$signed({1'b0, temp_data.nq}) : $signed({1'b0, temp_data.nq});
      hum_sum  = $signed({{(htc_pkg::SUM_W-htc_pkg::BASE_W){1'b0}}, hum_data.base})
               + $signed({{(htc_pkg::SUM_W-htc_pkg::NUM_W-1){hum_q[htc_pkg::NUM_W]}}, hum_q});
      temp_sum = $signed({{(htc_pkg::SUM_W-htc_pkg::BASE_W){1'b0}}, temp_data.base})
               + $signed({{(htc_pkg::SUM_W-htc_pkg::NUM_W-1){temp_q[htc_pkg::NUM_W]}}, temp_q});
      temp_sum_u = temp_sum;

      if (hum_data.bad || hum_sum[htc_pkg::SUM_W-1]) begin
         hum_in = '0;
      end else if (hum_sum > $signed({{(htc_pkg::SUM_W-htc_pkg::HUM_OUT_W){1'b0}},
                                      htc_pkg::HUM_MAX_X16})) begin
         hum_in = htc_pkg::HUM_MAX_X16;
      end else begin
         hum_in = hum_sum[htc_pkg::HUM_OUT_W-1:0];
      end

      if (temp_data.bad) begin
         temp_in     = '0;
         temp_sat_in = 1'b0;
      end else if (temp_sum > $signed({{(htc_pkg::SUM_W-htc_pkg::RAW_W){1'b0}},
                                       htc_pkg::TEMP_MAX})) begin
         temp_in     = htc_pkg::TEMP_MAX;
         temp_sat_in = 1'b1;
      end else if (temp_sum < $signed({{(htc_pkg::SUM_W-htc_pkg::RAW_W){1'b1}},
                                       htc_pkg::TEMP_MIN})) begin
         temp_in     = htc_pkg::TEMP_MIN;
         temp_sat_in = 1'b1;
      end else begin
         temp_in     = temp_sum_u[htc_pkg::RAW_W-1:0];
         temp_sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hum_ff      <= hum_in;
         temp_ff     <= temp_in;
         hum_bad_ff  <= hum_data.bad;
         temp_bad_ff <= temp_data.bad;
         temp_sat_ff <= temp_sat_in;
      end
   end

   assign out_valid       = valid_ff;
   assign humidity_x16    = hum_ff;
   assign temperature_x64 = temp_ff;
   assign hum_cal_bad     = hum_bad_ff;
   assign temp_cal_bad    = temp_bad_ff;
   assign temp_saturated  = temp_sat_ff;

endmodule

FILE: tb/humidity_temperature_calibrator_core_test.sv
// ----------------------------------------------------------------------------
// humidity_temperature_calibrator_core_test
// Self-checking bench for the two-point calibrator. Calibration points are
// loaded over the register port, raw reading pairs are streamed in and every
// result is compared field by field against an in-bench calculation of the
// interpolated, clamped and saturated values. Runs under several sender and
// receiver idling patterns, with one long result back-pressure stretch.
// ----------------------------------------------------------------------------
module humidity_temperature_calibrator_core_test;

   typedef struct packed {
      logic signed [htc_pkg::RAW_W-1:0] hum;
      logic signed [htc_pkg::RAW_W-1:0] temp;
   } raw_pair_type;

   typedef struct packed {
      logic [htc_pkg::HUM_OUT_W-1:0]    humidity_x16;
      logic signed [htc_pkg::RAW_W-1:0] temperature_x64;
      logic                             hum_cal_bad;
      logic                             temp_cal_bad;
      logic                             temp_saturated;
   } reading_type;

   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   htc_pkg::csr_index_type           csr_index = htc_pkg::CSR_HUM_POINT0;
   logic [htc_pkg::RAW_W-1:0]        csr_wdata = '0;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic signed [htc_pkg::RAW_W-1:0] req_hum_raw = '0;
   logic signed [htc_pkg::RAW_W-1:0] req_temp_raw = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [htc_pkg::HUM_OUT_W-1:0]    rsp_humidity_x16;
   logic signed [htc_pkg::RAW_W-1:0] rsp_temperature_x64;
   logic                             rsp_hum_cal_bad;
   logic                             rsp_temp_cal_bad;
   logic                             rsp_temp_saturated;

   // calibration as seen by the bench, updated on each register transfer
   logic [htc_pkg::HUM_PT_W-1:0]     cal_hum_point0 = '0;
   logic [htc_pkg::HUM_PT_W-1:0]     cal_hum_point1 = '0;
   logic signed [htc_pkg::RAW_W-1:0] cal_hum_raw0 = '0;
   logic signed [htc_pkg::RAW_W-1:0] cal_hum_raw1 = '0;
   logic [htc_pkg::PT_W-1:0]         cal_temp_point0 = '0;
   logic [htc_pkg::PT_W-1:0]         cal_temp_point1 = '0;
   logic signed [htc_pkg::RAW_W-1:0] cal_temp_raw0 = '0;
   logic signed [htc_pkg::RAW_W-1:0] cal_temp_raw1 = '0;

   raw_pair_type pending_pairs[$];
   reading_type  expected_readings[$];

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_request = 0;
   int  hold_seen = 0;
   int  hold_left = 0;
   bit  req_taken = 1'b0;
   int  error_count = 0;
   int  results_checked = 0;
   int  saturated_seen = 0;
   int  bad_cal_seen = 0;
   int  settings_used = 1;

   humidity_temperature_calibrator_core DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_hum_raw         (req_hum_raw),
      .req_temp_raw        (req_temp_raw),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_humidity_x16    (rsp_humidity_x16),
      .rsp_temperature_x64 (rsp_temperature_x64),
      .rsp_hum_cal_bad     (rsp_hum_cal_bad),
      .rsp_temp_cal_bad    (rsp_temp_cal_bad),
      .rsp_temp_saturated  (rsp_temp_saturated)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Straight line through both points, quotient truncated toward zero
   function automatic reading_type calibrate(input logic signed [htc_pkg::RAW_W-1:0] hum,
                                             input logic signed [htc_pkg::RAW_W-1:0] temp);
      reading_type r;
      longint      base;
      longint      span;
      longint      v;
      r = '0;
      if (cal_hum_raw0 == cal_hum_raw1) begin
         r.hum_cal_bad = 1'b1;
      end else begin
         base = 8 * longint'(cal_hum_point0);
         span = 8 * (longint'(cal_hum_point1) - longint'(cal_hum_point0));
         v = base + span * (longint'(hum) - longint'(cal_hum_raw0))
                  / (longint'(cal_hum_raw1) - longint'(cal_hum_raw0));
         if (v < 0) v = 0;
         if (v > longint'(htc_pkg::HUM_MAX_X16)) v = longint'(htc_pkg::HUM_MAX_X16);
         r.humidity_x16 = v[htc_pkg::HUM_OUT_W-1:0];
      end
      if (cal_temp_raw0 == cal_temp_raw1) begin
         r.temp_cal_bad = 1'b1;
      end else begin
         base = 8 * longint'(cal_temp_point0);
         span = 8 * (longint'(cal_temp_point1) - longint'(cal_temp_point0));
         v = base + span * (longint'(temp) - longint'(cal_temp_raw0))
                  / (longint'(cal_temp_raw1) - longint'(cal_temp_raw0));
         if (v > 32767) begin
            v = 32767;
            r.temp_saturated = 1'b1;
         end
         if (v < -32768) begin
            v = -32768;
            r.temp_saturated = 1'b1;
         end
         r.temperature_x64 = v[htc_pkg::RAW_W-1:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: %s", $time, msg);
      error_count++;
   endtask

   // Sender: a new pair only once the current one has been transferred
   always @(negedge clock) begin : request_driver
      raw_pair_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            item = pending_pairs.pop_front();
            req_valid    <= 1'b1;
            req_hum_raw  <= item.hum;
            req_temp_raw <= item.temp;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Long back-pressure stretch, armed from the stimulus process
   always @(negedge clock) begin : hold_counter
      if (hold_request != hold_seen) begin
         hold_seen <= hold_request;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(negedge clock) begin : result_receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : transfer_monitor
      reading_type got;
      reading_type want;
      req_taken = req_valid && req_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               htc_pkg::CSR_HUM_POINT0:  cal_hum_point0  = csr_wdata[htc_pkg::HUM_PT_W-1:0];
               htc_pkg::CSR_HUM_POINT1:  cal_hum_point1  = csr_wdata[htc_pkg::HUM_PT_W-1:0];
               htc_pkg::CSR_HUM_RAW0:    cal_hum_raw0    = csr_wdata;
               htc_pkg::CSR_HUM_RAW1:    cal_hum_raw1    = csr_wdata;
               htc_pkg::CSR_TEMP_POINT0: cal_temp_point0 = csr_wdata[htc_pkg::PT_W-1:0];
               htc_pkg::CSR_TEMP_POINT1: cal_temp_point1 = csr_wdata[htc_pkg::PT_W-1:0];
               htc_pkg::CSR_TEMP_RAW0:   cal_temp_raw0   = csr_wdata;
               htc_pkg::CSR_TEMP_RAW1:   cal_temp_raw1   = csr_wdata;
               default: ;
            endcase
         end
         if (req_taken) expected_readings.push_back(calibrate(req_hum_raw, req_temp_raw));
         if (rsp_valid === 1'b1 && rsp_ready) begin
            got.humidity_x16    = rsp_humidity_x16;
            got.temperature_x64 = rsp_temperature_x64;
            got.hum_cal_bad     = rsp_hum_cal_bad;
            got.temp_cal_bad    = rsp_temp_cal_bad;
            got.temp_saturated  = rsp_temp_saturated;
            if (expected_readings.size() == 0) begin
               report_mismatch("result transfer with nothing outstanding");
            end else begin
               want = expected_readings.pop_front();
               results_checked++;
               if (want.temp_saturated) saturated_seen++;
               if (want.hum_cal_bad || want.temp_cal_bad) bad_cal_seen++;
               if (got.humidity_x16 !== want.humidity_x16)
                  report_mismatch($sformatf("humidity_x16 got %0d expected %0d",
                                            got.humidity_x16, want.humidity_x16));
               if (got.temperature_x64 !== want.temperature_x64)
                  report_mismatch($sformatf("temperature_x64 got %0d expected %0d",
                                            got.temperature_x64, want.temperature_x64));
               if (got.hum_cal_bad !== want.hum_cal_bad)
                  report_mismatch($sformatf("hum_cal_bad got %b expected %b",
                                            got.hum_cal_bad, want.hum_cal_bad));
               if (got.temp_cal_bad !== want.temp_cal_bad)
                  report_mismatch($sformatf("temp_cal_bad got %b expected %b",
                                            got.temp_cal_bad, want.temp_cal_bad));
               if (got.temp_saturated !== want.temp_saturated)
                  report_mismatch($sformatf("temp_saturated got %b expected %b",
                                            got.temp_saturated, want.temp_saturated));
            end
         end
      end
   end

   task automatic write_reg(input htc_pkg::csr_index_type idx,
                            input logic [htc_pkg::RAW_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
   endtask

   task automatic load_calibration(input logic [htc_pkg::RAW_W-1:0] hp0, hp1, hr0, hr1,
                                   input logic [htc_pkg::RAW_W-1:0] tp0, tp1, tr0, tr1);
      write_reg(htc_pkg::CSR_HUM_POINT0, hp0);
      write_reg(htc_pkg::CSR_HUM_POINT1, hp1);
      write_reg(htc_pkg::CSR_HUM_RAW0, hr0);
      write_reg(htc_pkg::CSR_HUM_RAW1, hr1);
      write_reg(htc_pkg::CSR_TEMP_POINT0, tp0);
      write_reg(htc_pkg::CSR_TEMP_POINT1, tp1);
      write_reg(htc_pkg::CSR_TEMP_RAW0, tr0);
      write_reg(htc_pkg::CSR_TEMP_RAW1, tr1);
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // upper bits of the narrow point registers carry junk on purpose
   function automatic logic [htc_pkg::RAW_W-1:0] random_point_word();
      case ($urandom_range(5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // equal points now and then, small spans to push the temperature to its rails
   function automatic logic [htc_pkg::RAW_W-1:0] partner_raw(
         input logic [htc_pkg::RAW_W-1:0] first);
      case ($urandom_range(9))
         0:       return first;
         1:       return first + 16'($urandom_range(1, 16));
         2:       return first - 16'($urandom_range(1, 16));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic load_random_calibration();
      logic [htc_pkg::RAW_W-1:0] hr0;
      logic [htc_pkg::RAW_W-1:0] tr0;
      hr0 = 16'($urandom);
      tr0 = 16'($urandom);
      load_calibration(random_point_word(), random_point_word(), hr0, partner_raw(hr0),
                       random_point_word(), random_point_word(), tr0, partner_raw(tr0));
   endtask

   // readings cluster near the calibration points, with rails and noise
   function automatic logic [htc_pkg::RAW_W-1:0] random_reading(
         input logic [htc_pkg::RAW_W-1:0] a, b);
      case ($urandom_range(7))
         0:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
         1, 2:    return a + 16'($urandom_range(64)) - 16'd32;
         3, 4:    return b + 16'($urandom_range(64)) - 16'd32;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic push_pair(input logic [htc_pkg::RAW_W-1:0] hum, temp);
      raw_pair_type p;
      p.hum  = hum;
      p.temp = temp;
      pending_pairs.push_back(p);
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_pairs.size() != 0 || req_valid || expected_readings.size() != 0);
   endtask

   task automatic run_random(input int count, input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      repeat (count)
         push_pair(random_reading(cal_hum_raw0, cal_hum_raw1),
                   random_reading(cal_temp_raw0, cal_temp_raw1));
      wait_idle();
   endtask

   initial begin : stimulus
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset calibration: both lanes report a bad calibration
      push_pair(16'h0000, 16'h0000);
      push_pair(16'h7FFF, 16'h8000);
      wait_idle();

      // ordinary points; temperature span kept short so both rails are hit
      load_calibration(16'd40, 16'd150, -16'sd5000, 16'sd8000,
                       16'd80, 16'd480, 16'sd1000, 16'sd1400);
      push_pair(-16'sd5000, 16'sd1000);
      push_pair(16'sd8000, 16'sd1400);
      push_pair(16'h8000, 16'h8000);
      push_pair(16'h7FFF, 16'h7FFF);
      push_pair(16'h0000, 16'h0000);
      push_pair(16'hFFFF, 16'hFFFF);
      push_pair(16'h8000, 16'h7FFF);
      push_pair(16'h7FFF, 16'h8000);
      push_pair(16'sd1500, 16'sd1200);
      push_pair(-16'sd1500, 16'sd999);
      wait_idle();

      // widest spans, temperature running downhill
      load_calibration(16'h0000, 16'h00FF, 16'h8000, 16'h7FFF,
                       16'h03FF, 16'h0000, 16'h7FFF, 16'h8000);
      push_pair(16'h8000, 16'h8000);
      push_pair(16'h7FFF, 16'h7FFF);
      push_pair(16'h0000, 16'hFFFF);
      push_pair(16'h5555, 16'hAAAA);
      wait_idle();

      // unit denominators: largest gain either way
      load_calibration(16'h00FF, 16'h0000, 16'h0000, 16'h0001,
                       16'h03FF, 16'h0000, 16'hFFFF, 16'h0000);
      push_pair(16'h7FFF, 16'h7FFF);
      push_pair(16'h8000, 16'h8000);
      push_pair(16'h0000, 16'hFFFF);
      push_pair(16'h0001, 16'h0000);
      wait_idle();

      for (int phase = 0; phase < 12; phase++) begin
         load_random_calibration();
         case (phase % 4)
            0: run_random(85, 0, 0);
            1: run_random(85, 86, 0);
            2: run_random(85, 0, 86);
            default: run_random(85, 6, 6);
         endcase
      end

      // receiver holds off while the sender keeps offering, filling the pipe
      load_random_calibration();
      hold_request++;
      run_random(80, 0, 0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_readings.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_readings.size()));

      $display("checked %0d results over %0d calibration settings", results_checked,
               settings_used);
      $display("%0d saturated temperatures, %0d with a bad calibration flag",
               saturated_seen, bad_cal_seen);
      if (error_count == 0) begin
         $display("humidity_temperature_calibrator_core regression: pass");
      end else begin
         $display("humidity_temperature_calibrator_core regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("humidity_temperature_calibrator_core regression: fail");
      $finish;
   end

endmodule

FILE: humidity_temperature_calibrator_core.f
+incdir+rtl/core
rtl/core/htc_pkg.sv
rtl/core/htc_prep.sv
rtl/core/htc_div.sv
rtl/core/htc_post.sv
rtl/core/humidity_temperature_calibrator_core.sv
tb/humidity_temperature_calibrator_core_test.sv
